// File: rtl/core/qrr_pkg.sv
// qrr_pkg: status codes for the quadratic root pipeline
// used by quadratic_real_roots under rtl/core
package qrr_pkg;
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NEG = 2'd1;
    localparam logic [1:0] ST_AZ  = 2'd2;
    localparam logic [1:0] ST_SAT = 2'd3;
endpackage

// File: rtl/core/qrr_sqrt.sv
// qrr_sqrt: pipelined restoring integer square root, one result bit per stage
// depends on nothing; payload side band is carried alongside
module qrr_sqrt #(
    parameter int DW = 64,
    parameter int SW = 32,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_d,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [SW-1:0] o_s,
    output logic [PW-1:0] o_pay
);
    localparam int RW = SW + 2;
    logic [SW:0]        r_v;
    logic [DW-1:0]      r_d   [SW+1];
    logic [RW-1:0]      r_rem [SW+1];
    logic [SW-1:0]      r_q   [SW+1];
    logic [PW-1:0]      r_p   [SW+1];

    always_comb begin
        r_d[0]   = i_d;
        r_rem[0] = '0;
        r_q[0]   = '0;
        r_p[0]   = i_pay;
        r_v[0]   = i_vld;
    end

    for (genvar g = 0; g < SW; g++) begin : g_st
        logic [RW-1:0] n_rem, n_try;
        logic [DW-1:0] n_d;
        always_comb begin
            n_d   = r_d[g];
            n_rem = {r_rem[g][RW-3:0], n_d[DW-1 -: 2]};
            n_try = n_rem - {r_q[g], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_d[g+1] <= {n_d[DW-3:0], 2'b00};
                r_p[g+1] <= r_p[g];
                if (!n_try[RW-1]) begin
                    r_rem[g+1] <= n_try;
                    r_q[g+1]   <= {r_q[g][SW-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= n_rem;
                    r_q[g+1]   <= {r_q[g][SW-2:0], 1'b0};
                end
            end
        end
    end
    assign o_vld = r_v[SW];
    assign o_s   = r_q[SW];
    assign o_pay = r_p[SW];
endmodule

// File: rtl/core/qrr_div.sv
// qrr_div: pipelined restoring unsigned divider, one quotient bit per stage
// depends on nothing; payload side band is carried alongside
module qrr_div #(
    parameter int NW = 64,
    parameter int DW = 33,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [NW-1:0] o_q,
    output logic [PW-1:0] o_pay
);
    logic [NW:0]   r_v;
    logic [NW-1:0] r_n   [NW+1];
    logic [DW:0]   r_rem [NW+1];
    logic [DW-1:0] r_dn  [NW+1];
    logic [PW-1:0] r_p   [NW+1];

    always_comb begin
        r_n[0]   = i_num;
        r_rem[0] = '0;
        r_dn[0]  = i_den;
        r_p[0]   = i_pay;
        r_v[0]   = i_vld;
    end

    for (genvar g = 0; g < NW; g++) begin : g_st
        logic [DW:0] n_sh, n_df;
        always_comb begin
            n_sh = {r_rem[g][DW-1:0], r_n[g][NW-1]};
            n_df = n_sh - {1'b0, r_dn[g]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_dn[g+1] <= r_dn[g];
                r_p[g+1]  <= r_p[g];
                if (!n_df[DW]) begin
                    r_rem[g+1] <= n_df;
                    r_n[g+1]   <= {r_n[g][NW-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= n_sh;
                    r_n[g+1]   <= {r_n[g][NW-2:0], 1'b0};
                end
            end
        end
    end
    assign o_vld = r_v[NW];
    assign o_q   = r_n[NW];
    assign o_pay = r_p[NW];
endmodule

// File: rtl/core/quadratic_real_roots.sv
// quadratic_real_roots: top level, discriminant, square root, two dividers, saturation
// depends on qrr_pkg, qrr_sqrt, qrr_div
//
// Gives both real roots of a*x^2+b*x+c in signed fixed point for each item. One item is
// accepted every cycle while the output is not stalled; the pipeline has three front stages,
// WORD_BITS+1 square root stages, one numerator stage, WORD_BITS+FRAC_BITS+2 divider stages
// and the output register. The whole pipeline halts while the
// output register holds an untaken item. Status: 0 ok, 1 negative discriminant, 2 a is
// zero, 3 a root saturated; roots read zero for status 1 and 2.
module quadratic_real_roots
    import qrr_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // coef_a, coef_b, coef_c
    input  logic [((3*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // root_plus, root_minus, status
    output logic [((2*WORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    localparam int W  = WORD_BITS;
    localparam int DW = 2*W + 2;          // discriminant width (even)
    localparam int SW = DW/2;             // sqrt width
    localparam int MW = W + 2;            // |-b +/- s| width
    localparam int NW = MW + FRAC_BITS;   // numerator width
    localparam int AW = W + 1;            // 2|a| width
    localparam int PW = 2 + 1 + 1 + W + 1 + W;
    localparam int OW = ((2*W+2+7)/8)*8;

    logic en;
    logic r_ov;
    assign en = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: magnitudes and signs
    logic [W-1:0] ia, ib, ic;
    assign ia = s_axis_tdata[W-1:0];
    assign ib = s_axis_tdata[2*W-1:W];
    assign ic = s_axis_tdata[3*W-1:2*W];
    logic r1_v, r1_an, r1_bn, r1_cn;
    logic [W-1:0] r1_am, r1_bm, r1_cm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= s_axis_tvalid;
        if (en) begin
            r1_an <= ia[W-1]; r1_bn <= ib[W-1]; r1_cn <= ic[W-1];
            r1_am <= ia[W-1] ? W'(-ia) : ia;
            r1_bm <= ib[W-1] ? W'(-ib) : ib;
            r1_cm <= ic[W-1] ? W'(-ic) : ic;
        end
    end
    // magnitude of most negative value is 2^(W-1) which the W-bit pattern holds unsigned

    // stage 2: products
    logic r2_v, r2_an, r2_bn, r2_add, r2_az;
    logic [W-1:0] r2_am, r2_bm;
    logic [2*W-1:0] r2_bb, r2_ac;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
        if (en) begin
            r2_bb  <= r1_bm * r1_bm;
            r2_ac  <= r1_am * r1_cm;
            r2_an  <= r1_an; r2_bn <= r1_bn; r2_am <= r1_am; r2_bm <= r1_bm;
            r2_add <= (r1_cm != '0) && (r1_an != r1_cn);
            r2_az  <= (r1_am == '0);
        end
    end

    // stage 3: discriminant
    logic [DW-1:0] n_bb, n_ac4, n_d;
    logic [1:0]    n_st3;
    always_comb begin
        n_bb  = DW'(r2_bb);
        n_ac4 = {r2_ac, 2'b00};
        n_st3 = ST_OK;
        if (r2_add) n_d = n_bb + n_ac4;
        else        n_d = n_bb - n_ac4;
        if (r2_az) n_st3 = ST_AZ;
        else if (!r2_add && n_ac4 > n_bb) n_st3 = ST_NEG;
    end
    logic r3_v;
    logic [DW-1:0] r3_d;
    logic [PW-1:0] r3_p;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
        if (en) begin
            r3_d <= (n_st3 == ST_OK) ? n_d : '0;
            r3_p <= {n_st3, r2_an, r2_bn, r2_am, 1'b0, r2_bm};
        end
    end

    logic s_v;
    logic [SW-1:0] s_s;
    logic [PW-1:0] s_p;
    qrr_sqrt #(.DW(DW), .SW(SW), .PW(PW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r3_v),
        .i_d(r3_d), .i_pay(r3_p), .o_vld(s_v), .o_s(s_s), .o_pay(s_p)
    );

    // stage 4: numerators
    logic [1:0]   s_st;
    logic         s_an, s_bn;
    logic [W-1:0] s_am, s_bm;
    assign s_st = s_p[PW-1:PW-2];
    assign s_an = s_p[PW-3];
    assign s_bn = s_p[PW-4];
    assign s_am = s_p[2*W:W+1];
    assign s_bm = s_p[W-1:0];
    logic signed [MW:0] n_nb, n_np, n_nm;
    always_comb begin
        n_nb = s_bn ? (MW+1)'(s_bm) : -(MW+1)'(s_bm);
        n_np = n_nb + (MW+1)'(s_s);
        n_nm = n_nb - (MW+1)'(s_s);
    end
    logic r4_v;
    logic [NW-1:0] r4_np, r4_nm;
    logic [AW-1:0] r4_den;
    logic [PW-1:0] r4_p;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= s_v;
        if (en) begin
            r4_np  <= {MW'(n_np[MW] ? -n_np : n_np), {FRAC_BITS{1'b0}}};
            r4_nm  <= {MW'(n_nm[MW] ? -n_nm : n_nm), {FRAC_BITS{1'b0}}};
            r4_den <= {s_am, 1'b0};
            r4_p   <= {s_st, n_np[MW] != s_an, n_nm[MW] != s_an, {(PW-4){1'b0}}};
        end
    end

    logic d_v, d_v2;
    logic [NW-1:0] q_p, q_m;
    logic [PW-1:0] d_p, d_p2;
    qrr_div #(.NW(NW), .DW(AW), .PW(PW)) u_div_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r4_v), .i_num(r4_np),
        .i_den(r4_den), .i_pay(r4_p), .o_vld(d_v), .o_q(q_p), .o_pay(d_p)
    );
    qrr_div #(.NW(NW), .DW(AW), .PW(PW)) u_div_m (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r4_v), .i_num(r4_nm),
        .i_den(r4_den), .i_pay(r4_p), .o_vld(d_v2), .o_q(q_m), .o_pay(d_p2)
    );

    // final stage: sign, saturation, output register
    function automatic logic [W:0] f_fin(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] lim;
        logic [W-1:0]  mag;
        logic          sat;
        lim = neg ? (NW'(1) << (W-1)) : ((NW'(1) << (W-1)) - NW'(1));
        sat = q > lim;
        mag = sat ? W'(lim) : W'(q);
        return {sat, neg ? W'(-mag) : mag};
    endfunction

    logic [W:0] n_rp, n_rm;
    logic [1:0] n_st;
    always_comb begin
        n_rp = f_fin(q_p, d_p[PW-3]);
        n_rm = f_fin(q_m, d_p[PW-4]);
        n_st = d_p[PW-1:PW-2];
        if (n_st == ST_OK && (n_rp[W] || n_rm[W])) n_st = ST_SAT;
    end
    logic [OW-1:0] r_od;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= d_v && d_v2;
        if (en) begin
            if (d_p[PW-1:PW-2] != ST_OK || d_p2[PW-1:PW-2] != ST_OK)
                r_od <= OW'({n_st, {(2*W){1'b0}}});
            else
                r_od <= OW'({n_st, n_rm[W-1:0], n_rp[W-1:0]});
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
endmodule
